// ===== rtl/bmc_pkg.sv =====
package bmc_pkg;

	typedef logic [7:0] byte_t;

	typedef enum logic [2:0] {
		ST_EXEC  = 3'd0,
		ST_PRINT = 3'd1,
		ST_HALT  = 3'd2,
		ST_BADOP = 3'd3,
		ST_WRITE = 3'd4
	} status_t;

	localparam byte_t OP_HALT  = 8'd0;
	localparam byte_t OP_PRINT = 8'd1;
	localparam byte_t OP_INC   = 8'd2;
	localparam byte_t OP_DEC   = 8'd3;
	localparam byte_t OP_JMP   = 8'd4;
	localparam byte_t OP_BNZ   = 8'd5;

	// microprogram addresses
	typedef enum logic [3:0] {
		UP_IDLE  = 4'd0,
		UP_WR    = 4'd1,
		UP_HLT   = 4'd2,
		UP_E0    = 4'd3,
		UP_E1    = 4'd4,
		UP_E2    = 4'd5,
		UP_HALT  = 4'd6,
		UP_PRINT = 4'd7,
		UP_INC   = 4'd8,
		UP_DEC   = 4'd9,
		UP_JMP   = 4'd10,
		UP_BNZ0  = 4'd11,
		UP_BNZ1  = 4'd12,
		UP_BNZ2  = 4'd13,
		UP_BAD   = 4'd14
	} step_t;

	typedef enum logic [2:0] {
		A_PC   = 3'd0,
		A_PC1  = 3'd1,
		A_PC2  = 3'd2,
		A_DATA = 3'd3,
		A_IN   = 3'd4,
		A_A1   = 3'd5,
		A_OP   = 3'd6
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_IN  = 2'd0,
		WD_INC = 2'd1,
		WD_DEC = 2'd2
	} wd_sel_t;

	typedef enum logic [2:0] {
		PC_KEEP = 3'd0,
		PC_IN   = 3'd1,
		PC_ADD2 = 3'd2,
		PC_A1   = 3'd3,
		PC_RMW  = 3'd4,
		PC_BNZ  = 3'd5
	} pc_sel_t;

	typedef enum logic [1:0] {
		H_KEEP = 2'd0,
		H_SET  = 2'd1,
		H_CLR  = 2'd2
	} halt_sel_t;

	typedef enum logic [1:0] {
		V_ZERO = 2'd0,
		V_A1   = 2'd1,
		V_OP   = 2'd2
	} val_sel_t;

	typedef enum logic [1:0] {
		BR_SEQ      = 2'd0,
		BR_START    = 2'd1,
		BR_DISPATCH = 2'd2
	} br_t;

	typedef struct packed {
		addr_sel_t addr_sel;
		logic      mem_we;
		wd_sel_t   wd_sel;
		logic      ld_op;
		logic      ld_a1;
		pc_sel_t   pc_sel;
		halt_sel_t halt_sel;
		logic      fin;
		status_t   status;
		val_sel_t  val_sel;
		br_t       br;
		step_t     nxt;
	} cword_t;

	typedef struct packed {
		cword_t cw;
		logic   accept;
		logic   go;
	} ctl_t;

	typedef struct packed {
		logic  halted;
		byte_t op;
		logic  zero;
		logic  out_free;
	} flags_t;

	function automatic cword_t ucode(step_t s);
		cword_t cw;
		cw = '{addr_sel: A_PC, mem_we: 1'b0, wd_sel: WD_IN, ld_op: 1'b0, ld_a1: 1'b0,
			pc_sel: PC_KEEP, halt_sel: H_KEEP, fin: 1'b0, status: ST_EXEC,
			val_sel: V_ZERO, br: BR_SEQ, nxt: UP_IDLE};
		unique case (s)
			UP_IDLE: begin
				cw.br = BR_START;
			end
			UP_WR: begin
				cw.addr_sel = A_IN;
				cw.mem_we   = 1'b1;
				cw.wd_sel   = WD_IN;
				cw.pc_sel   = PC_IN;
				cw.halt_sel = H_CLR;
				cw.fin      = 1'b1;
				cw.status   = ST_WRITE;
			end
			UP_HLT: begin
				cw.fin    = 1'b1;
				cw.status = ST_HALT;
			end
			UP_E0: begin
				cw.addr_sel = A_PC;
				cw.nxt      = UP_E1;
			end
			UP_E1: begin
				cw.addr_sel = A_PC1;
				cw.ld_op    = 1'b1;
				cw.nxt      = UP_E2;
			end
			UP_E2: begin
				// operand arrives now; start reading the byte it points at
				cw.addr_sel = A_DATA;
				cw.ld_a1    = 1'b1;
				cw.br       = BR_DISPATCH;
			end
			UP_HALT: begin
				cw.halt_sel = H_SET;
				cw.fin      = 1'b1;
				cw.status   = ST_HALT;
			end
			UP_PRINT: begin
				cw.pc_sel  = PC_ADD2;
				cw.fin     = 1'b1;
				cw.status  = ST_PRINT;
				cw.val_sel = V_A1;
			end
			UP_INC: begin
				cw.addr_sel = A_A1;
				cw.mem_we   = 1'b1;
				cw.wd_sel   = WD_INC;
				cw.pc_sel   = PC_RMW;
				cw.fin      = 1'b1;
			end
			UP_DEC: begin
				cw.addr_sel = A_A1;
				cw.mem_we   = 1'b1;
				cw.wd_sel   = WD_DEC;
				cw.pc_sel   = PC_RMW;
				cw.fin      = 1'b1;
			end
			UP_JMP: begin
				cw.pc_sel = PC_A1;
				cw.fin    = 1'b1;
			end
			UP_BNZ0: begin
				cw.addr_sel = A_PC2;
				cw.nxt      = UP_BNZ1;
			end
			UP_BNZ1: begin
				// op_q is free after dispatch; it keeps the branch test address
				cw.addr_sel = A_DATA;
				cw.ld_op    = 1'b1;
				cw.nxt      = UP_BNZ2;
			end
			UP_BNZ2: begin
				// keep reading the test byte so a stall sees the same data
				cw.addr_sel = A_OP;
				cw.pc_sel   = PC_BNZ;
				cw.fin      = 1'b1;
			end
			UP_BAD: begin
				cw.halt_sel = H_SET;
				cw.fin      = 1'b1;
				cw.status   = ST_BADOP;
				cw.val_sel  = V_OP;
			end
			default: begin
				cw.nxt = UP_IDLE;
			end
		endcase
		return cw;
	endfunction

	function automatic step_t dispatch(byte_t op);
		step_t s;
		unique case (op)
			OP_HALT:  s = UP_HALT;
			OP_PRINT: s = UP_PRINT;
			OP_INC:   s = UP_INC;
			OP_DEC:   s = UP_DEC;
			OP_JMP:   s = UP_JMP;
			OP_BNZ:   s = UP_BNZ0;
			default:  s = UP_BAD;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/bmc_req_if.sv =====
interface bmc_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] address;
	logic [7:0] data;

	modport source (output valid, output req_type, output address, output data, input ready);
	modport sink (input valid, input req_type, input address, input data, output ready);
endinterface

// ===== rtl/bmc_rsp_if.sv =====
interface bmc_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] value;
	logic [7:0] program_counter;

	modport source (output valid, output status, output value, output program_counter,
		input ready);
	modport sink (input valid, input status, input value, input program_counter,
		output ready);
endinterface

// ===== rtl/bmc_ram.sv =====
module bmc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/bmc_seq.sv =====
module bmc_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_type,
	output logic            req_ready,
	input  bmc_pkg::flags_t flags,
	output bmc_pkg::ctl_t   ctl
);
	import bmc_pkg::*;

	step_t  upc_q, upc_d;
	cword_t cw;
	logic   accept;
	logic   go;

	assign cw        = ucode(upc_q);
	assign req_ready = (upc_q == UP_IDLE);
	assign accept    = req_ready & req_valid;
	// a finishing step waits until the output register is free
	assign go        = ~cw.fin | flags.out_free;
	assign ctl       = '{cw: cw, accept: accept, go: go};

	always_comb begin
		upc_d = upc_q;
		if (go) begin
			unique case (cw.br)
				BR_SEQ: begin
					upc_d = cw.nxt;
				end
				BR_START: begin
					if (accept) begin
						if (!req_type) begin
							upc_d = UP_WR;
						end else if (flags.halted) begin
							upc_d = UP_HLT;
						end else begin
							upc_d = UP_E0;
						end
					end
				end
				BR_DISPATCH: begin
					upc_d = dispatch(flags.op);
				end
				default: begin
					upc_d = UP_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UP_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end
endmodule

// ===== rtl/bmc_dp.sv =====
module bmc_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  bmc_pkg::ctl_t   ctl,
	input  bmc_pkg::byte_t  req_address,
	input  bmc_pkg::byte_t  req_data,
	input  logic            rsp_ready,
	output logic            rsp_valid,
	output logic [2:0]      rsp_status,
	output bmc_pkg::byte_t  rsp_value,
	output bmc_pkg::byte_t  rsp_pc,
	output bmc_pkg::flags_t flags
);
	import bmc_pkg::*;

	// byte 0 lives in pc_q; the RAM copy of byte 0 is never used
	byte_t in_addr_q, in_data_q;
	byte_t op_q, a1_q, pc_q, snap_q;
	logic  zero_q;
	logic  halted_q;
	byte_t rdata, data, addr, wd, pc_d, val;
	logic  we;

	assign data = zero_q ? snap_q : rdata;

	always_comb begin
		unique case (ctl.cw.addr_sel)
			A_PC:    addr = pc_q;
			A_PC1:   addr = pc_q + 8'd1;
			A_PC2:   addr = pc_q + 8'd2;
			A_DATA:  addr = data;
			A_IN:    addr = in_addr_q;
			A_A1:    addr = a1_q;
			A_OP:    addr = op_q;
			default: addr = pc_q;
		endcase
	end

	always_comb begin
		unique case (ctl.cw.wd_sel)
			WD_IN:   wd = in_data_q;
			WD_INC:  wd = data + 8'd1;
			WD_DEC:  wd = data - 8'd1;
			default: wd = in_data_q;
		endcase
	end

	always_comb begin
		unique case (ctl.cw.pc_sel)
			PC_KEEP: pc_d = pc_q;
			PC_IN:   pc_d = (in_addr_q == 8'd0) ? in_data_q : pc_q;
			PC_ADD2: pc_d = pc_q + 8'd2;
			PC_A1:   pc_d = a1_q;
			// data write lands first, then the pc advance
			PC_RMW:  pc_d = ((a1_q == 8'd0) ? wd : pc_q) + 8'd2;
			PC_BNZ:  pc_d = (data == 8'd0) ? pc_q + 8'd3 : a1_q;
			default: pc_d = pc_q;
		endcase
	end

	always_comb begin
		unique case (ctl.cw.val_sel)
			V_ZERO:  val = 8'd0;
			V_A1:    val = a1_q;
			V_OP:    val = op_q;
			default: val = 8'd0;
		endcase
	end

	assign we = ctl.cw.mem_we & ctl.go;

	bmc_ram #(.WIDTH(8), .DEPTH(256)) u_ram (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata (wd),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			in_addr_q <= req_address;
			in_data_q <= req_data;
		end
		if (ctl.cw.ld_op) begin
			op_q <= data;
		end
		if (ctl.cw.ld_a1) begin
			a1_q <= data;
		end
		if (ctl.go) begin
			pc_q <= pc_d;
		end
		zero_q <= (addr == 8'd0);
		snap_q <= pc_q;
		if (ctl.cw.fin && ctl.go) begin
			rsp_status <= ctl.cw.status;
			rsp_value  <= val;
			rsp_pc     <= pc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (ctl.go) begin
				priority case (ctl.cw.halt_sel)
					H_SET:   halted_q <= 1'b1;
					H_CLR:   halted_q <= 1'b0;
					default: halted_q <= halted_q;
				endcase
			end
			if (ctl.cw.fin && ctl.go) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	assign flags = '{halted: halted_q, op: op_q, zero: (data == 8'd0),
		out_free: ~rsp_valid | rsp_ready};
endmodule

// ===== rtl/byte_memory_toy_cpu_step_top.sv =====
// Byte-memory toy CPU, one request word in, one response word out.
// req: req_type 0 stores data at address and clears the halt flag;
//      req_type 1 executes the instruction at memory[memory[0]] unless halted.
// rsp: status, value and program_counter (memory byte 0 after the request).
// Control is a microprogram in a small ROM; its step counter walks the
// single-port 256-byte RAM (registered read) through fetch, operand and
// data accesses, one RAM access per cycle.
// A write or a step while halted goes from accept straight to its finishing
// step; an instruction passes through fetch, operand and dispatch steps, and
// opcode 5 adds reads of its second operand and the byte that it points at.
// The block takes one request at a time and is ready again in the same cycle
// that the response appears in the output register.
// The response sits in an output register; the next request is accepted
// while it waits. If rsp.ready stays low, the next finishing step holds
// until the register is free.
// Reset clears the sequencer, the halt flag and the response valid. Memory,
// including the program counter byte, is undefined until written.
module byte_memory_toy_cpu_step_top (
	input  logic     clk,
	input  logic     arst_n,
	bmc_req_if.sink  req,
	bmc_rsp_if.source rsp
);
	import bmc_pkg::*;

	ctl_t   ctl;
	flags_t flags;

	bmc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.flags     (flags),
		.ctl       (ctl)
	);

	bmc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.req_address (req.address),
		.req_data    (req.data),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.rsp_status  (rsp.status),
		.rsp_value   (rsp.value),
		.rsp_pc      (rsp.program_counter),
		.flags       (flags)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("sequencer ready right after accepting a word");

	a_finish_loads_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cw.fin && ctl.go |=> rsp.valid)
		else $error("finished step did not produce a response");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !(rsp.status == ST_PRINT || rsp.status == ST_BADOP)
		|-> rsp.value == 8'd0)
		else $error("nonzero value on a response without print or error");
`endif
endmodule
